[sv/vwbf_pkg.sv]
// ----------------------------------------------------------------------------
// vwbf_pkg
// shared types and constants of the variable width bit fifo
// ----------------------------------------------------------------------------
`default_nettype none

package vwbf_pkg;

  localparam int DEPTH_BITS = 1024;
  localparam int MAX_ACCESS = 32;
  localparam int WORD_W     = 32;
  localparam int OFF_W      = $clog2(WORD_W);
  localparam int PTR_W      = $clog2(DEPTH_BITS);
  localparam int FREE_W     = PTR_W + 1;
  localparam int CNT_W      = 6;
  localparam int VAL_W      = 32;
  localparam int NUM_WORDS  = DEPTH_BITS / WORD_W;
  localparam int WIDX_W     = PTR_W - OFF_W;
  localparam int BANK_DEPTH = NUM_WORDS / 2;
  localparam int ROW_W      = WIDX_W - 1;
  localparam int IN_W       = 40;
  localparam int OUT_W      = 56;

  typedef enum logic [1:0] {
    CMD_PUT  = 2'd0,
    CMD_FILL = 2'd1,
    CMD_GET  = 2'd2
  } cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_RMW
  } state_e;

endpackage

`default_nettype wire

[sv/variable_width_bit_fifo_unit.sv]
// ----------------------------------------------------------------------------
// variable_width_bit_fifo_unit
// bit ring buffer with put, zero fill and get of 0 to 32 bits per transaction
// ----------------------------------------------------------------------------
// path: an accepted transaction and its reads of the two word banks that hold
//   the bits are registered, and the result goes to the output or skid register;
//   no new transaction is taken until the write back is done and the skid is empty
// reset: pointers and handshake state clear asynchronously, the bit store
//   keeps its contents and a get returns only bits that were put or filled
`default_nettype none

module variable_width_bit_fifo_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // cmd[1:0], bit_count[7:2], put_value[39:8]
  input  wire logic [vwbf_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // ok[0], get_value[32:1], fill_level[42:33], free_space[53:43], zero[55:54]
  output logic      [vwbf_pkg::OUT_W-1:0]  m_axis_tdata
);

  localparam int PW = vwbf_pkg::PTR_W;
  localparam int WW = vwbf_pkg::WORD_W;
  localparam int RW = vwbf_pkg::ROW_W;
  localparam int XW = vwbf_pkg::WIDX_W;
  localparam int CW = vwbf_pkg::CNT_W;

  vwbf_pkg::state_e state_q, state_d;
  logic accept, start;

  logic [PW-1:0] rp_q, rp_d, wp_q, wp_d;
  logic [PW-1:0] fill_cur, fill_q, fill_d;

  vwbf_pkg::cmd_e  in_cmd;
  logic [CW-1:0]   in_cnt;
  logic [WW-1:0]   in_val;

  vwbf_pkg::cmd_e         cmd_q;
  logic [CW-1:0]          cnt_q;
  logic [WW-1:0]          val_q;
  logic [vwbf_pkg::OFF_W-1:0] off_q, off_d;
  logic                   lo_odd_q, lo_odd_d;
  logic [RW-1:0]          addr_e_q, addr_e_d, addr_o_q, addr_o_d;
  logic                   ok_q, ok_d;

  logic [XW-1:0] wi, wn;
  logic [PW-1:0] base;

  logic [WW-1:0] rd_e, rd_o, lo, hi, new_lo, new_hi;
  logic [2*WW-1:0] pair, mask64, data64, new_pair, shifted;
  logic [WW-1:0] mask32, get_val;
  logic we;
  logic [vwbf_pkg::FREE_W-1:0] free_space;
  logic [vwbf_pkg::OUT_W-1:0] result;

  logic out_valid_q, skid_valid_q;
  logic [vwbf_pkg::OUT_W-1:0] out_data_q, skid_data_q;

  assign in_cmd = vwbf_pkg::cmd_e'(s_axis_tdata[1:0]);
  assign in_cnt = s_axis_tdata[7:2];
  assign in_val = s_axis_tdata[39:8];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      vwbf_pkg::ST_IDLE: begin
        if (accept) state_d = vwbf_pkg::ST_RMW;
      end
      vwbf_pkg::ST_RMW: state_d = vwbf_pkg::ST_IDLE;
      default: state_d = vwbf_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    start         = 1'b0;
    case (state_q)
      vwbf_pkg::ST_IDLE: s_axis_tready = !skid_valid_q;
      vwbf_pkg::ST_RMW:  start = 1'b1;
      default: s_axis_tready = 1'b0;
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  // decision and pointer update at accept
  always_comb begin
    fill_cur = wp_q - rp_q;
    ok_d = 1'b0;
    if (in_cnt <= CW'(vwbf_pkg::MAX_ACCESS)) begin
      case (in_cmd)
        vwbf_pkg::CMD_PUT, vwbf_pkg::CMD_FILL:
          ok_d = ({1'b0, fill_cur} + (PW+1)'(in_cnt)) <= (PW+1)'(vwbf_pkg::DEPTH_BITS - 1);
        vwbf_pkg::CMD_GET:
          ok_d = PW'(in_cnt) <= fill_cur;
        default: ok_d = 1'b0;
      endcase
    end
    rp_d = rp_q;
    wp_d = wp_q;
    if (ok_d && in_cmd == vwbf_pkg::CMD_GET) rp_d = rp_q + PW'(in_cnt);
    if (ok_d && in_cmd != vwbf_pkg::CMD_GET) wp_d = wp_q + PW'(in_cnt);
    fill_d = wp_d - rp_d;
    base = (in_cmd == vwbf_pkg::CMD_GET) ? rp_q : wp_q;
    off_d = base[vwbf_pkg::OFF_W-1:0];
    wi = base[PW-1:vwbf_pkg::OFF_W];
    wn = wi + XW'(1);
    lo_odd_d = wi[0];
    addr_e_d = wi[0] ? wn[XW-1:1] : wi[XW-1:1];
    addr_o_d = wi[0] ? wi[XW-1:1] : wn[XW-1:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vwbf_pkg::ST_IDLE;
      rp_q    <= '0;
      wp_q    <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        rp_q <= rp_d;
        wp_q <= wp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= in_cmd;
      cnt_q    <= in_cnt;
      val_q    <= in_val;
      off_q    <= off_d;
      lo_odd_q <= lo_odd_d;
      addr_e_q <= addr_e_d;
      addr_o_q <= addr_o_d;
      ok_q     <= ok_d;
      fill_q   <= fill_d;
    end
  end

  vwbf_ram #(.WIDTH(WW), .DEPTH(vwbf_pkg::BANK_DEPTH)) u_bank_even (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr_e_q),
    .wdata_i (lo_odd_q ? new_hi : new_lo),
    .raddr_i (addr_e_d),
    .rdata_o (rd_e)
  );

  vwbf_ram #(.WIDTH(WW), .DEPTH(vwbf_pkg::BANK_DEPTH)) u_bank_odd (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr_o_q),
    .wdata_i (lo_odd_q ? new_lo : new_hi),
    .raddr_i (addr_o_d),
    .rdata_o (rd_o)
  );

  // read modify write of the word pair
  always_comb begin
    lo = lo_odd_q ? rd_o : rd_e;
    hi = lo_odd_q ? rd_e : rd_o;
    pair = {hi, lo};
    if (cnt_q >= CW'(WW)) mask32 = '1;
    else mask32 = (WW'(1) << cnt_q[vwbf_pkg::OFF_W-1:0]) - WW'(1);
    mask64 = {{WW{1'b0}}, mask32} << off_q;
    data64 = (cmd_q == vwbf_pkg::CMD_PUT) ? ({{WW{1'b0}}, val_q} << off_q) : '0;
    new_pair = (pair & ~mask64) | (data64 & mask64);
    new_lo = new_pair[WW-1:0];
    new_hi = new_pair[2*WW-1:WW];
    we = start && ok_q && (cmd_q != vwbf_pkg::CMD_GET) && (cnt_q != '0);
    shifted = pair >> off_q;
    get_val = (ok_q && cmd_q == vwbf_pkg::CMD_GET) ? (shifted[WW-1:0] & mask32) : '0;
    free_space = vwbf_pkg::FREE_W'(vwbf_pkg::DEPTH_BITS) - {1'b0, fill_q};
    result = {2'b00, free_space, fill_q, get_val, ok_q};
  end

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || m_axis_tready) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= start;
        end
      end else if (start) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
        if (start) skid_data_q <= result;
      end else if (start) begin
        out_data_q <= result;
      end
    end else if (start) begin
      skid_data_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

[sv/vwbf_ram.sv]
// ----------------------------------------------------------------------------
// vwbf_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module vwbf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[verif/tb_variable_width_bit_fifo_unit.sv]
// ----------------------------------------------------------------------------
// tb_variable_width_bit_fifo_unit
// self-checking bench: directed table then random put, fill, get and unknown command
// traffic, each result compared with a table entry or a bit-queue predictor under varied idle and stall phases
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_variable_width_bit_fifo_unit;

  localparam int CAPACITY  = vwbf_pkg::DEPTH_BITS - 1;
  localparam int CYC_LIMIT = 400000;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  typedef struct packed {
    logic                        ok;
    logic [31:0]                 get_value;
    logic [vwbf_pkg::PTR_W-1:0]  fill_level;
    logic [vwbf_pkg::FREE_W-1:0] free_space;
  } result_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [5:0]  cnt;
    logic [31:0] val;
    logic        has_res;
    result_t     res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [vwbf_pkg::IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [vwbf_pkg::OUT_W-1:0] m_axis_tdata;

  variable_width_bit_fifo_unit dut (.*);

  always #5 clk_i = ~clk_i;

  bit      stored_bits[$];
  result_t expected_results[$];
  int      error_count = 0;
  int      cycle_count = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;

  function automatic result_t predict_command(logic [1:0] cmd, logic [5:0] cnt,
                                              logic [31:0] val);
    result_t r;
    int fill;
    fill = stored_bits.size();
    r = '0;
    if (cnt <= vwbf_pkg::MAX_ACCESS) begin
      if (cmd == vwbf_pkg::CMD_PUT || cmd == vwbf_pkg::CMD_FILL) begin
        if (fill + cnt <= CAPACITY) begin
          for (int i = 0; i < cnt; i++)
            stored_bits.push_back(cmd == vwbf_pkg::CMD_PUT ? val[i] : 1'b0);
          r.ok = 1'b1;
        end
      end else if (cmd == vwbf_pkg::CMD_GET) begin
        if (cnt <= fill) begin
          for (int i = 0; i < cnt; i++) r.get_value[i] = stored_bits.pop_front();
          r.ok = 1'b1;
        end
      end
    end
    r.fill_level = vwbf_pkg::PTR_W'(stored_bits.size());
    r.free_space = vwbf_pkg::FREE_W'(vwbf_pkg::DEPTH_BITS - stored_bits.size());
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, exp,
             cycle_count);
    error_count++;
  endtask

  task automatic send_command(logic [1:0] cmd, logic [5:0] cnt, logic [31:0] val,
                              logic has_res, result_t res);
    result_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {val, cnt, cmd};
    p = predict_command(cmd, cnt, val);
    expected_results.push_back(has_res ? res : p);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // receiver stall and result check
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    result_t got, exp;
    cycle_count <= cycle_count + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.ok         = m_axis_tdata[0];
      got.get_value  = m_axis_tdata[32:1];
      got.fill_level = m_axis_tdata[42:33];
      got.free_space = m_axis_tdata[53:43];
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction", 32'(got.ok), 32'd0);
      end else begin
        exp = expected_results.pop_front();
        if (got.ok !== exp.ok) report_mismatch("ok", 32'(got.ok), 32'(exp.ok));
        if (got.get_value !== exp.get_value)
          report_mismatch("get_value", got.get_value, exp.get_value);
        if (got.fill_level !== exp.fill_level)
          report_mismatch("fill_level", 32'(got.fill_level), 32'(exp.fill_level));
        if (got.free_space !== exp.free_space)
          report_mismatch("free_space", 32'(got.free_space), 32'(exp.free_space));
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count >= CYC_LIMIT) begin
      $display("timeout");
      $display("Verification failed");
      $finish;
    end
  end

  task automatic random_command();
    int k;
    logic [5:0] cnt;
    k = $urandom_range(99);
    cnt = ($urandom_range(19) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(32));
    if (k < 3) send_command(CMD_UNKNOWN, cnt, $urandom(), 1'b0, '0);
    else if (k < 45) send_command(vwbf_pkg::CMD_PUT, cnt, $urandom(), 1'b0, '0);
    else if (k < 55) send_command(vwbf_pkg::CMD_FILL, cnt, $urandom(), 1'b0, '0);
    else send_command(vwbf_pkg::CMD_GET, cnt, $urandom(), 1'b0, '0);
  endtask

  row_t table_rows[$];

  task automatic add_row(logic [1:0] cmd, logic [5:0] cnt, logic [31:0] val,
                         logic has_res, result_t res);
    row_t r;
    r.cmd = cmd; r.cnt = cnt; r.val = val; r.has_res = has_res; r.res = res;
    table_rows.push_back(r);
  endtask

  initial begin
    add_row(vwbf_pkg::CMD_GET, 6'd1, 32'h0, 1'b1, '{1'b0, 32'h0, 10'd0, 11'd1024});
    add_row(vwbf_pkg::CMD_GET, 6'd0, 32'h0, 1'b1, '{1'b1, 32'h0, 10'd0, 11'd1024});
    add_row(vwbf_pkg::CMD_PUT, 6'd32, 32'hffffffff, 1'b1,
            '{1'b1, 32'h0, 10'd32, 11'd992});
    add_row(vwbf_pkg::CMD_GET, 6'd32, 32'h0, 1'b1,
            '{1'b1, 32'hffffffff, 10'd0, 11'd1024});
    add_row(vwbf_pkg::CMD_PUT, 6'd33, 32'h1, 1'b1, '{1'b0, 32'h0, 10'd0, 11'd1024});
    add_row(CMD_UNKNOWN, 6'd4, 32'h5, 1'b1, '{1'b0, 32'h0, 10'd0, 11'd1024});
    add_row(vwbf_pkg::CMD_PUT, 6'd0, 32'hffffffff, 1'b1,
            '{1'b1, 32'h0, 10'd0, 11'd1024});
    add_row(vwbf_pkg::CMD_FILL, 6'd63, 32'h0, 1'b1, '{1'b0, 32'h0, 10'd0, 11'd1024});
    add_row(vwbf_pkg::CMD_PUT, 6'd32, 32'h0, 1'b1, '{1'b1, 32'h0, 10'd32, 11'd992});
    add_row(vwbf_pkg::CMD_PUT, 6'd7, 32'h5a, 1'b0, '0);
    add_row(vwbf_pkg::CMD_FILL, 6'd5, 32'hffffffff, 1'b0, '0);
    add_row(vwbf_pkg::CMD_PUT, 6'd32, 32'ha5c3_0f96, 1'b0, '0);
    add_row(vwbf_pkg::CMD_GET, 6'd13, 32'h0, 1'b0, '0);
    add_row(vwbf_pkg::CMD_GET, 6'd33, 32'h0, 1'b0, '0);
    add_row(vwbf_pkg::CMD_GET, 6'd32, 32'h0, 1'b0, '0);
    add_row(vwbf_pkg::CMD_GET, 6'd32, 32'h0, 1'b0, '0);
    add_row(vwbf_pkg::CMD_GET, 6'd30, 32'h0, 1'b0, '0);
    add_row(vwbf_pkg::CMD_GET, 6'd1, 32'h0, 1'b0, '0);

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (table_rows[i]) send_command(table_rows[i].cmd, table_rows[i].cnt,
                                         table_rows[i].val, table_rows[i].has_res,
                                         table_rows[i].res);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        3: begin send_idle_pct = 20; recv_stall_pct = 20; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < 120; n++) random_command();
      // drive near full to reach the capacity refusal
      if (ph == 0 || ph == 4)
        for (int n = 0; n < 40; n++)
          send_command(vwbf_pkg::CMD_PUT, 6'd32, $urandom(), 1'b0, '0);
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (error_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
